// ===== design/fba_pkg.sv =====
// Shared types, constants and state encoding for the frame bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none

package fba_pkg;

	// Field widths fixed by the request and result formats
	localparam int FRAME_W = 12;
	localparam int COUNT_W = 13;

	// Default sizing of the bitmap
	localparam int MAX_FRAMES_DEF = 4096;
	localparam int WORD_BITS_DEF  = 32;

	// Configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_FRAME_COUNT = 1'b0;
	localparam logic [COUNT_W-1:0] FRAME_COUNT_RST = 13'd4096;

	// Request kinds
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	typedef struct packed {
		logic               action;
		logic [FRAME_W-1:0] current_frame;
		logic               kernel_page;
		logic               page_rw;
	} fba_req_t;

	typedef struct packed {
		logic               no_free_frame;
		logic               entry_updated;
		logic               user_mode;
		logic               writable;
		logic               present;
		logic [FRAME_W-1:0] frame;
	} fba_result_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SPLIT,
		ST_FREE_RD,
		ST_FREE_WR,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_RESULT
	} fba_state_t;

endpackage

`default_nettype wire

// ===== design/fba_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module fba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic [AW-1:0]    addr,
	input  wire logic             we,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

// ===== design/fba_apb_regs.sv =====
// APB register block holding the frame count.
`timescale 1ns / 1ps
`default_nettype none

module fba_apb_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [fba_pkg::APB_AW-1:0]   paddr,
	input  wire logic [fba_pkg::APB_DW-1:0]   pwdata,
	output logic      [fba_pkg::APB_DW-1:0]   prdata,
	output logic                              pready,
	output logic      [fba_pkg::COUNT_W-1:0]  frame_count
);

	logic reg_hit;

	// register index is the word address
	assign reg_hit = (paddr[fba_pkg::APB_AW-1] == fba_pkg::REG_FRAME_COUNT);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count <= fba_pkg::FRAME_COUNT_RST;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			frame_count <= pwdata[fba_pkg::COUNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_hit) begin
			prdata = {{(fba_pkg::APB_DW - fba_pkg::COUNT_W){1'b0}}, frame_count};
		end
	end

endmodule

`default_nettype wire

// ===== design/fba_engine.sv =====
// Allocation engine: clearing pass, bitmap scan, read-modify-write and result register.
`timescale 1ns / 1ps
`default_nettype none

module fba_engine #(
	parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEF,
	parameter int WORD_BITS  = fba_pkg::WORD_BITS_DEF,
	parameter int NUM_WORDS  = MAX_FRAMES / WORD_BITS,
	parameter int AW         = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [fba_pkg::COUNT_W-1:0] frame_count,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire fba_pkg::fba_req_t           in_req,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output fba_pkg::fba_result_t             out_res,
	output logic      [AW-1:0]               ram_addr,
	output logic                             ram_we,
	output logic      [WORD_BITS-1:0]        ram_wdata,
	input  wire logic [WORD_BITS-1:0]        ram_rdata
);

	localparam int FW = fba_pkg::FRAME_W;
	localparam int SW = $clog2(NUM_WORDS + 1);
	localparam int BW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
	localparam int LW0 = $clog2((NUM_WORDS + 1) * WORD_BITS + 1);
	localparam int LW = (LW0 > fba_pkg::COUNT_W) ? LW0 : fba_pkg::COUNT_W;
	localparam int DW = (AW > FW) ? AW : FW;
	// reciprocal of the word size, exact after one correction step
	localparam int DIV_SH = FW + 7;
	localparam int RW = DIV_SH + 1;
	localparam int RECIP = (1 << DIV_SH) / WORD_BITS;
	localparam int MW = FW + RW;

	fba_pkg::fba_state_t state_q, state_d;

	fba_pkg::fba_req_t    req_q;
	fba_pkg::fba_result_t res_q, res_d;
	fba_pkg::fba_result_t out_q;
	logic                 out_valid_q;

	logic [SW-1:0] clr_q;
	logic [SW-1:0] lo_q;
	logic [SW-1:0] scan_q;
	logic [DW-1:0] q_est_q;
	logic [AW-1:0] w_q;
	logic [BW-1:0] b_q;

	logic          accept;
	logic          load_out;
	logic          res_load;
	logic [MW-1:0] recip_prod;
	logic [DW-1:0] q_est_d;
	logic [DW-1:0] qd_prod;
	logic [DW-1:0] r_raw;
	logic          r_big;
	logic [DW-1:0] q_fix;
	logic [DW-1:0] r_fix;
	logic [LW-1:0] scan_end;
	logic          scan_ok;
	logic          word_full;
	logic [BW-1:0] zero_j;
	logic [LW-1:0] found_frame;

	assign in_ready  = (state_q == fba_pkg::ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign load_out  = (state_q == fba_pkg::ST_RESULT) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// word and bit of the frame to free
	assign recip_prod = MW'(in_req.current_frame) * MW'(RECIP);
	assign q_est_d    = DW'(recip_prod >> DIV_SH);
	assign qd_prod    = q_est_q * DW'(WORD_BITS);
	assign r_raw      = DW'(req_q.current_frame) - qd_prod;
	assign r_big      = (r_raw >= DW'(WORD_BITS));
	assign q_fix      = r_big ? q_est_q + DW'(1) : q_est_q;
	assign r_fix      = r_big ? r_raw - DW'(WORD_BITS) : r_raw;

	// a word is searched only if it lies wholly below the frame count
	assign scan_end = (LW'(scan_q) + LW'(1)) * LW'(WORD_BITS);
	assign scan_ok  = (scan_q < SW'(NUM_WORDS)) && (scan_end <= LW'(frame_count));

	assign word_full = &ram_rdata;

	always_comb begin
		zero_j = '0;
		for (int k = WORD_BITS - 1; k >= 0; k--) begin
			if (!ram_rdata[k]) begin
				zero_j = BW'(k);
			end
		end
	end

	assign found_frame = LW'(scan_q) * LW'(WORD_BITS) + LW'(zero_j);

	always_comb begin
		state_d   = state_q;
		res_d     = '0;
		res_load  = 1'b0;
		ram_addr  = scan_q[AW-1:0];
		ram_we    = 1'b0;
		ram_wdata = '0;
		case (state_q)
			fba_pkg::ST_CLEAR: begin
				ram_addr = clr_q[AW-1:0];
				ram_we   = 1'b1;
				if (clr_q == SW'(NUM_WORDS - 1)) begin
					state_d = fba_pkg::ST_IDLE;
				end
			end
			fba_pkg::ST_IDLE: begin
				if (accept) begin
					if (in_req.action == fba_pkg::ACT_FREE) begin
						if (in_req.current_frame == '0) begin
							res_load = 1'b1;
							state_d  = fba_pkg::ST_RESULT;
						end else if (LW'(in_req.current_frame) >= LW'(MAX_FRAMES)) begin
							res_d.entry_updated = 1'b1;
							res_load = 1'b1;
							state_d  = fba_pkg::ST_RESULT;
						end else begin
							state_d = fba_pkg::ST_SPLIT;
						end
					end else if (in_req.current_frame != '0) begin
						res_d.frame = in_req.current_frame;
						res_load = 1'b1;
						state_d  = fba_pkg::ST_RESULT;
					end else begin
						state_d = fba_pkg::ST_SCAN_RD;
					end
				end
			end
			fba_pkg::ST_SPLIT: begin
				state_d = fba_pkg::ST_FREE_RD;
			end
			fba_pkg::ST_FREE_RD: begin
				ram_addr = w_q;
				state_d  = fba_pkg::ST_FREE_WR;
			end
			fba_pkg::ST_FREE_WR: begin
				ram_addr  = w_q;
				ram_we    = 1'b1;
				ram_wdata = ram_rdata & ~(WORD_BITS'(1) << b_q);
				res_d.entry_updated = 1'b1;
				res_load = 1'b1;
				state_d  = fba_pkg::ST_RESULT;
			end
			fba_pkg::ST_SCAN_RD: begin
				if (scan_ok) begin
					state_d = fba_pkg::ST_SCAN_CHK;
				end else begin
					res_d.no_free_frame = 1'b1;
					res_load = 1'b1;
					state_d  = fba_pkg::ST_RESULT;
				end
			end
			fba_pkg::ST_SCAN_CHK: begin
				if (word_full) begin
					state_d = fba_pkg::ST_SCAN_RD;
				end else begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata | (WORD_BITS'(1) << zero_j);
					res_d.frame         = found_frame[FW-1:0];
					res_d.present       = 1'b1;
					res_d.writable      = req_q.page_rw;
					res_d.user_mode     = !req_q.kernel_page;
					res_d.entry_updated = 1'b1;
					res_load = 1'b1;
					state_d  = fba_pkg::ST_RESULT;
				end
			end
			fba_pkg::ST_RESULT: begin
				if (load_out) begin
					state_d = fba_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fba_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fba_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// clearing counter, scan pointer and lowest word that may hold a free frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			lo_q   <= '0;
			scan_q <= '0;
		end else begin
			if (state_q == fba_pkg::ST_CLEAR) begin
				clr_q <= clr_q + SW'(1);
			end
			if (accept) begin
				scan_q <= lo_q;
			end
			if (state_q == fba_pkg::ST_SCAN_RD && !scan_ok) begin
				lo_q <= scan_q;
			end
			if (state_q == fba_pkg::ST_SCAN_CHK) begin
				if (word_full) begin
					scan_q <= scan_q + SW'(1);
				end else begin
					lo_q <= scan_q;
				end
			end
			if (state_q == fba_pkg::ST_FREE_WR && SW'(w_q) < lo_q) begin
				lo_q <= SW'(w_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= in_req;
			q_est_q <= q_est_d;
		end
		if (state_q == fba_pkg::ST_SPLIT) begin
			w_q <= q_fix[AW-1:0];
			b_q <= r_fix[BW-1:0];
		end
		if (res_load) begin
			res_q <= res_d;
		end
		if (load_out) begin
			out_q <= res_q;
		end
	end

endmodule

`default_nettype wire

// ===== design/frame_bitmap_allocator.sv =====
// Top level of the first-fit bitmap page frame allocator.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-----------------------------------------
//  s_*      | in        | s_tvalid / s_tready | s_tuser: action; s_tdata: frame, flags
//  m_*      | out       | m_tvalid / m_tready | m_tdata: frame, pte bits, status
//  apb      | in        | psel+penable/pready | frame_count at address 0
//
// Steps: an allocation reads the bitmap words in turn (one RAM read, then one
// check of the returned word) until it finds a free frame, which it sets and
// reports, or runs out of words. A free splits the frame number, reads the
// word, writes it back and loads the result. Requests with nothing to do go
// straight to the result. The single-port bitmap RAM bounds the work: every
// word touched costs one read and at most one write, one request at a time.
// Reset: a clearing pass writes zero to all MAX_FRAMES/WORD_BITS words, one a
// cycle (128 words by default), with s_tready low; configuration writes go on.
// Stalls: a finished result waits in the output register while the next request
// is taken; the engine holds in its result state only if that register is full.
`timescale 1ns / 1ps
`default_nettype none

module frame_bitmap_allocator #(
	parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEF,
	parameter int WORD_BITS  = fba_pkg::WORD_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// slave stream
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [15:0]                s_tdata,  // current_frame[11:0], kernel_page, page_rw, pad
	input  wire logic                       s_tuser,  // action
	// master stream
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic      [23:0]                m_tdata,  // frame[11:0], present, writable, user_mode,
	                                                  // entry_updated, no_free_frame, pad
	// configuration
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [fba_pkg::APB_AW-1:0] paddr,
	input  wire logic [fba_pkg::APB_DW-1:0] pwdata,
	output logic      [fba_pkg::APB_DW-1:0] prdata,
	output logic                            pready
);

	localparam int NUM_WORDS = MAX_FRAMES / WORD_BITS;
	localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int FW = fba_pkg::FRAME_W;

	logic [fba_pkg::COUNT_W-1:0] frame_count;
	fba_pkg::fba_req_t           req;
	fba_pkg::fba_result_t        res;

	logic [AW-1:0]        ram_addr;
	logic                 ram_we;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [WORD_BITS-1:0] ram_rdata;

	// unpack the request: action on tuser, the rest on tdata from bit 0 up
	always_comb begin
		req.action        = s_tuser;
		req.current_frame = s_tdata[FW-1:0];
		req.kernel_page   = s_tdata[FW];
		req.page_rw       = s_tdata[FW+1];
	end

	// pack the result from bit 0 up, zero fill to whole bytes
	assign m_tdata = {7'b0, res.no_free_frame, res.entry_updated, res.user_mode,
		res.writable, res.present, res.frame};

	fba_apb_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.frame_count (frame_count)
	);

	fba_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (NUM_WORDS),
		.AW    (AW)
	) u_bitmap (
		.clk   (clk),
		.addr  (ram_addr),
		.we    (ram_we),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	fba_engine #(
		.MAX_FRAMES (MAX_FRAMES),
		.WORD_BITS  (WORD_BITS),
		.NUM_WORDS  (NUM_WORDS),
		.AW         (AW)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_count (frame_count),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_req      (req),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_res     (res),
		.ram_addr    (ram_addr),
		.ram_we      (ram_we),
		.ram_wdata   (ram_wdata),
		.ram_rdata   (ram_rdata)
	);

endmodule

`default_nettype wire
